// File: rtl/core/id_allocator_fifo_free_list_assert.svh
// Assertion macros used by the identifier allocator top level.
`ifndef ID_ALLOCATOR_FIFO_FREE_LIST_ASSERT_SVH
`define ID_ALLOCATOR_FIFO_FREE_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IDA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IDA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ida_pkg.sv
// Shared codes and control structs for the identifier allocator.
package ida_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NULL = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   // Write control for the slot store.
   typedef struct packed {
      logic en;
      logic occupied;
   } slot_wr_type;

   // Push and pop control for the free queue.
   typedef struct packed {
      logic push;
      logic pop;
   } fq_ctrl_type;

endpackage

// File: rtl/core/ida_slot_store.sv
// Slot store: per-slot occupied flag and handle, with registered read and write bypass.
module ida_slot_store
   import ida_pkg::*;
#(
   parameter int SLOTS       = 64,
   parameter int HANDLE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   input  slot_wr_type              wr_ctrl,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  logic [HANDLE_BITS-1:0]   wr_handle,
   output logic                     rd_occupied,
   output logic [HANDLE_BITS-1:0]   rd_handle
);

   localparam int ROW_BITS = HANDLE_BITS + 1;

   logic [ROW_BITS-1:0] mem [SLOTS];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic [ROW_BITS-1:0] byp_data_ff;
   logic                byp_ff;
   logic                byp_in;
   logic [ROW_BITS-1:0] wr_row;

   assign wr_row = {wr_ctrl.occupied, wr_handle};

   // A write to the address being read at the same edge wins over the old row.
   assign byp_in = wr_ctrl.en && (wr_addr == rd_addr);

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_ctrl.en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // Memory read port, registered.
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[rd_addr];
      byp_data_ff <= wr_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign {rd_occupied, rd_handle} = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

// File: rtl/core/ida_free_queue.sv
// Free queue: circular buffer of released identifiers with the head entry always on view.
module ida_free_queue
   import ida_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fq_ctrl_type                ctrl,
   input  logic [$clog2(SLOTS)-1:0]   push_id,
   output logic [$clog2(SLOTS)-1:0]   head_id,
   output logic [$clog2(SLOTS+1)-1:0] fill
);

   localparam int ID_BITS  = $clog2(SLOTS);
   localparam int CNT_BITS = $clog2(SLOTS + 1);
   localparam logic [ID_BITS-1:0] LAST_IDX = ID_BITS'(SLOTS - 1);

   logic [ID_BITS-1:0]  mem [SLOTS];
   logic [ID_BITS-1:0]  head_ff, head_in;
   logic [ID_BITS-1:0]  tail_ff, tail_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic [ID_BITS-1:0]  rd_data_ff;
   logic [ID_BITS-1:0]  byp_data_ff;
   logic                byp_ff;

   // Pointer and fill count updates; wrap at the last slot.
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.pop) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end
      if (ctrl.push) begin
         tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         byp_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         byp_ff  <= ctrl.push && (tail_ff == head_in);
      end
   end

   // Push writes at the tail.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= push_id;
      end
   end

   // The entry at the next head is read every cycle so the oldest id is ready.
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[head_in];
      byp_data_ff <= push_id;
   end

   assign head_id = byp_ff ? byp_data_ff : rd_data_ff;
   assign fill    = fill_ff;

endmodule

// File: rtl/core/id_allocator_fifo_free_list.sv
// Top level of the slot identifier allocator with a first-in first-out free list.
//
// Usage: a request transaction (req_op, req_slot_id, req_entry_handle) is taken at a
// rising edge where start is high and busy is low. Ops are allocate, free and look up.
// Every request yields exactly one response transaction, shown on the rsp_ ports for
// one cycle while rsp_valid is high; the receiver cannot stall and must take it then.
// A request taken at an edge is held in the request register, then its response in the
// response register, from which it is consumed. Throughput is one request per cycle,
// back to back. The request register's edge also registers the reads of the slot store
// and the free queue, and a write at the same edge as a read is bypassed, so
// consecutive requests see each other's updates.
// Reset is synchronous and active high. It empties the free queue and clears the
// high-water mark and the live count; busy is high while reset is held. Slot contents
// need no clearing, since only slots below the high-water mark are ever read and each
// of those was written when it was handed out.
`include "id_allocator_fifo_free_list_assert.svh"

module id_allocator_fifo_free_list
   import ida_pkg::*;
#(
   parameter int SLOTS       = 64,
   parameter int HANDLE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_op,
   input  logic [$clog2(SLOTS)-1:0]   req_slot_id,
   input  logic [HANDLE_BITS-1:0]     req_entry_handle,
   output logic                       rsp_valid,
   output logic [$clog2(SLOTS)-1:0]   rsp_granted_id,
   output logic [1:0]                 rsp_status,
   output logic [HANDLE_BITS-1:0]     rsp_handle_out,
   output logic [$clog2(SLOTS+1)-1:0] rsp_live_count
);

   localparam int ID_BITS = $clog2(SLOTS);
   localparam int HW_BITS = $clog2(SLOTS + 1);
   localparam logic [HW_BITS-1:0] SLOTS_HW = HW_BITS'(SLOTS);

   logic                   busy_ff;
   logic                   accept;

   // Request register.
   logic                   valid_ff;
   logic [1:0]             op_ff;
   logic [ID_BITS-1:0]     slot_ff;
   logic [HANDLE_BITS-1:0] handle_ff;

   // Allocator state.
   logic [HW_BITS-1:0]     hw_ff, hw_in;
   logic [HW_BITS-1:0]     count_ff, count_in;

   // Response register.
   logic                   rsp_valid_ff;
   logic [ID_BITS-1:0]     granted_ff, granted_in;
   logic [1:0]             status_ff, status_in;
   logic [HANDLE_BITS-1:0] hout_ff, hout_in;
   logic [HW_BITS-1:0]     live_ff;

   // Links to the slot store and free queue.
   slot_wr_type            swr_ctrl;
   logic [ID_BITS-1:0]     swr_addr;
   logic                   st_rd_occupied;
   logic [HANDLE_BITS-1:0] st_rd_handle;
   fq_ctrl_type            fq_ctrl;
   logic [ID_BITS-1:0]     fq_head_id;
   logic [HW_BITS-1:0]     fq_fill;
   logic                   slot_live;

   assign accept = start && !busy_ff;

   // Busy covers the reset period only.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   // Capture the request transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         slot_ff   <= req_slot_id;
         handle_ff <= req_entry_handle;
      end
   end

   ida_slot_store #(
      .SLOTS       (SLOTS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_slot_store (
      .clock       (clock),
      .reset       (reset),
      .rd_addr     (req_slot_id),
      .wr_ctrl     (swr_ctrl),
      .wr_addr     (swr_addr),
      .wr_handle   (handle_ff),
      .rd_occupied (st_rd_occupied),
      .rd_handle   (st_rd_handle)
   );

   ida_free_queue #(
      .SLOTS   (SLOTS)
   ) u_free_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (fq_ctrl),
      .push_id (slot_ff),
      .head_id (fq_head_id),
      .fill    (fq_fill)
   );

   // A slot is live when it was handed out at some point and is still occupied.
   assign slot_live = (HW_BITS'(slot_ff) < hw_ff) && st_rd_occupied;

   // Decide the response and state updates for the registered request.
   always_comb begin
      granted_in = '0;
      status_in  = ST_BAD;
      hout_in    = '0;
      hw_in      = hw_ff;
      count_in   = count_ff;
      swr_ctrl   = '0;
      swr_addr   = slot_ff;
      fq_ctrl    = '0;
      if (valid_ff) begin
         unique case (op_ff)
            OP_ALLOC: begin
               if (handle_ff == '0) begin
                  status_in = ST_NULL;
               end else if (fq_fill != '0) begin
                  fq_ctrl.pop = 1'b1;
                  swr_addr    = fq_head_id;
               end else if (hw_ff < SLOTS_HW) begin
                  hw_in    = hw_ff + 1'b1;
                  swr_addr = hw_ff[ID_BITS-1:0];
               end else begin
                  status_in = ST_FULL;
               end
               if (status_in == ST_BAD) begin
                  swr_ctrl.en       = 1'b1;
                  swr_ctrl.occupied = 1'b1;
                  count_in          = count_ff + 1'b1;
                  granted_in        = swr_addr;
                  status_in         = ST_OK;
               end
            end
            OP_FREE: begin
               if (slot_live) begin
                  swr_ctrl.en  = 1'b1;
                  fq_ctrl.push = 1'b1;
                  count_in     = count_ff - 1'b1;
                  status_in    = ST_OK;
               end
            end
            OP_LOOKUP: begin
               if (slot_live) begin
                  hout_in   = st_rd_handle;
                  status_in = ST_OK;
               end
            end
            default: begin
               status_in = ST_BAD;
            end
         endcase
      end
   end

   // Allocator state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff    <= '0;
         count_ff <= '0;
      end else begin
         hw_ff    <= hw_in;
         count_ff <= count_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         granted_ff <= granted_in;
         status_ff  <= status_in;
         hout_ff    <= hout_in;
         live_ff    <= count_in;
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = granted_ff;
   assign rsp_status     = status_ff;
   assign rsp_handle_out = hout_ff;
   assign rsp_live_count = live_ff;

   // Every accepted request reaches the request register, and a response follows only a registered request.
   `IDA_ASSERT_NEXT(a_req_to_stage, clock, reset, accept, valid_ff, "request lost in pipeline")
   `IDA_ASSERT_NEXT(a_no_spurious, clock, reset, !valid_ff, !rsp_valid_ff, "spurious response")
   // Every slot handed out is either occupied or waiting on the free queue.
   `IDA_ASSERT_NOW(a_slot_balance, clock, reset, 1'b1,
      ({1'b0, count_ff} + {1'b0, fq_fill}) == {1'b0, hw_ff}, "slot accounting broken")
   // Only a successful request carries an identifier or a handle.
   `IDA_ASSERT_NOW(a_clean_fail, clock, reset, rsp_valid_ff && (status_ff != ST_OK),
      (granted_ff == '0) && (hout_ff == '0), "failed response carries data")

endmodule
